// ----- hw/rtl/sog_pkg.sv -----
// Shared types, constants and sine table function for the sine oscillator with glide.
package sog_pkg;

    localparam int FREQ_W  = 31;
    localparam int NS_W    = 7;
    localparam int SMP_W   = 13;
    localparam int PHASE_W = 32;
    localparam int SCALE_W = 36;
    localparam int DIV_CNT_W = $clog2(FREQ_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(FREQ_W - 1);

    localparam logic [SCALE_W-1:0] SCALE_RESET = 36'd5864062014;
    localparam logic [PHASE_W-1:0] STEP_RESET  = 32'd44739243;
    localparam logic [FREQ_W-1:0]  FREQ_RESET  = 31'd32768000;

    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned AMP     = 64'd4095;
    localparam longint unsigned SIN_COEF [5] = '{
        64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026993, 64'd172272
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_READ,
        ST_LOAD,
        ST_MUL,
        ST_INC,
        ST_ADV,
        ST_CFG_MUL,
        ST_CFG_INC
    } sog_state_t;

    typedef struct packed {
        logic accept;
        logic setup;
        logic div_step;
        logic load;
        logic freq_step;
        logic mul;
        logic inc;
        logic phase_add;
        logic snap;
    } sog_cmd_t;

    typedef struct packed {
        logic glide;
        logic glide_mode;
        logic div_last;
        logic rem_one;
        logic rem_zero;
        logic out_free;
        logic req_zero;
    } sog_status_t;

    function automatic logic [SMP_W-1:0] sine_entry(int unsigned a_bits, int unsigned idx);
        longint unsigned addr_ph;
        longint unsigned quad;
        longint unsigned u;
        longint unsigned x2;
        longint unsigned p;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        addr_ph = (longint'(idx) << (32 - a_bits)) & 64'hFFFF_FFFF;
        quad = (addr_ph >> 30) & 64'd3;
        u = addr_ph & 64'h3FFF_FFFF;
        if (quad[0])
        begin
            u = Q30_ONE - u;
        end
        x2 = (u * u) >> 30;
        p = SIN_COEF[4];
        for (int i = 3; i >= 0; i--)
        begin
            t = (p * x2) >> 30;
            p = (SIN_COEF[i] > t) ? SIN_COEF[i] - t : 64'd0;
        end
        s = (p * u) >> 30;
        v = (s * AMP + (64'd1 << 29)) >> 30;
        if (v > AMP)
        begin
            v = AMP;
        end
        if (quad[1])
        begin
            v = 64'd0 - v;
        end
        return v[SMP_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/sog_if.sv -----
// Valid/ready channel interfaces for block requests and output samples.
interface sog_req_if;
    logic                        valid;
    logic                        ready;
    logic [sog_pkg::FREQ_W-1:0]  target_freq;
    logic [sog_pkg::NS_W-1:0]    num_samples;

    modport source (output valid, output target_freq, output num_samples, input ready);
    modport sink (input valid, input target_freq, input num_samples, output ready);
endinterface

interface sog_smp_if;
    logic                             valid;
    logic                             ready;
    logic signed [sog_pkg::SMP_W-1:0] sample_value;
    logic                             last;

    modport source (output valid, output sample_value, output last, input ready);
    modport sink (input valid, input sample_value, input last, output ready);
endinterface

// ----- hw/rtl/sog_sine_rom.sv -----
// Sine lookup table with registered read, contents computed at elaboration.
module sog_sine_rom #(
    parameter int ADDR_W = 10
) (
    input  logic                      clk,
    input  logic [ADDR_W-1:0]         addr,
    output logic [sog_pkg::SMP_W-1:0] data
);
    import sog_pkg::*;

    logic [SMP_W-1:0] rom_w [2**ADDR_W];
    logic [SMP_W-1:0] data_reg;

    for (genvar i = 0; i < 2**ADDR_W; i++)
    begin : g_entry
        localparam logic [SMP_W-1:0] VALUE = sine_entry(ADDR_W, i);
        assign rom_w[i] = VALUE;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_w[addr];
    end

    assign data = data_reg;
endmodule

// ----- hw/rtl/sog_ctrl.sv -----
// Controller state machine that sequences division, sample output and increment updates.
module sog_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic                 cfg_we,
    input  sog_pkg::sog_status_t status,
    output sog_pkg::sog_cmd_t    cmd
);
    import sog_pkg::*;

    sog_state_t state_reg;
    sog_state_t state_next;
    logic       can_accept;

    assign can_accept = (state_reg == ST_IDLE) && !cfg_we;
    assign req_ready  = can_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_we)
                begin
                    state_next = ST_CFG_MUL;
                end
                else if (req_valid && !status.req_zero)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:   state_next = status.glide ? ST_DIV : ST_READ;
            ST_DIV:     state_next = status.div_last ? ST_READ : ST_DIV;
            ST_READ:    state_next = ST_LOAD;
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    if (status.glide_mode)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        state_next = status.rem_one ? ST_IDLE : ST_READ;
                    end
                end
            end
            ST_MUL:     state_next = ST_INC;
            ST_INC:     state_next = ST_ADV;
            ST_ADV:     state_next = status.rem_zero ? ST_IDLE : ST_READ;
            ST_CFG_MUL: state_next = ST_CFG_INC;
            ST_CFG_INC: state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.accept    = can_accept && req_valid;
        cmd.setup     = (state_reg == ST_SETUP);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.load      = (state_reg == ST_LOAD) && status.out_free;
        cmd.freq_step = cmd.load && status.glide_mode;
        cmd.mul       = (state_reg == ST_MUL) || (state_reg == ST_CFG_MUL);
        cmd.inc       = (state_reg == ST_INC) || (state_reg == ST_CFG_INC);
        cmd.phase_add = (cmd.load && !status.glide_mode) || (state_reg == ST_ADV);
        cmd.snap      = (state_reg == ST_ADV) && status.rem_zero;
    end
endmodule

// ----- hw/rtl/sog_datapath.sv -----
// Datapath with frequency, phase, divider, increment multiplier and output register.
module sog_datapath #(
    parameter int MAX_BLOCK = 64,
    parameter int ADDR_W    = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sog_pkg::sog_cmd_t                cmd,
    output sog_pkg::sog_status_t             status,
    input  logic                             cfg_we,
    input  logic [sog_pkg::SCALE_W-1:0]      cfg_wdata,
    input  logic [sog_pkg::FREQ_W-1:0]       req_target_freq,
    input  logic [sog_pkg::NS_W-1:0]         req_num_samples,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic signed [sog_pkg::SMP_W-1:0] out_sample,
    output logic                             out_last,
    output logic [ADDR_W-1:0]                rom_addr,
    input  logic [sog_pkg::SMP_W-1:0]        rom_data
);
    import sog_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam logic [NS_W-1:0] MAX_NS = NS_W'(MAX_BLOCK);

    logic [SCALE_W-1:0]   scale_reg;
    logic [PHASE_W-1:0]   phase_reg;
    logic [PHASE_W-1:0]   phase_next;
    logic [PHASE_W-1:0]   step_reg;
    logic [PHASE_W-1:0]   step_next;
    logic [FREQ_W-1:0]    freq_reg;
    logic [FREQ_W-1:0]    freq_next;
    logic                 glide_reg;
    logic                 up_reg;
    logic                 out_valid_reg;

    logic [FREQ_W-1:0]    target_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     remain_reg;
    logic [FREQ_W-1:0]    div_reg;
    logic [FREQ_W-1:0]    div_next;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [62:0]          prod_lo_reg;
    logic [31:0]          prod_hi_reg;
    logic [SMP_W-1:0]     sample_reg;
    logic                 last_reg;

    logic [NS_W-1:0]      sat_count;
    logic [CNT_W:0]       trial;
    logic                 trial_ge;
    logic [CNT_W:0]       trial_diff;
    logic [34:0]          hi_full;
    logic [63:0]          rounded;

    assign sat_count  = (req_num_samples > MAX_NS) ? MAX_NS : req_num_samples;
    assign trial      = {rem_reg, div_reg[FREQ_W-1]};
    assign trial_ge   = trial >= {1'b0, count_reg};
    assign trial_diff = trial - {1'b0, count_reg};
    assign hi_full    = {4'd0, freq_reg} * {31'd0, scale_reg[SCALE_W-1:32]};
    assign rounded    = {1'b0, prod_lo_reg} + 64'h0000_0000_8000_0000;

    always_comb
    begin
        rem_next = trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
        div_next = {div_reg[FREQ_W-2:0], trial_ge};
        if (cmd.setup)
        begin
            rem_next = '0;
            div_next = (target_reg > freq_reg) ? target_reg - freq_reg : freq_reg - target_reg;
        end
    end

    always_comb
    begin
        freq_next = freq_reg;
        if (cmd.freq_step)
        begin
            freq_next = up_reg ? freq_reg + div_reg : freq_reg - div_reg;
        end
        else if (cmd.snap)
        begin
            freq_next = target_reg;
        end
    end

    assign step_next  = prod_hi_reg + rounded[63:32];
    assign phase_next = phase_reg + step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= SCALE_RESET;
            phase_reg     <= '0;
            step_reg      <= STEP_RESET;
            freq_reg      <= FREQ_RESET;
            glide_reg     <= 1'b0;
            up_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                scale_reg <= cfg_wdata;
            end
            if (cmd.phase_add)
            begin
                phase_reg <= phase_next;
            end
            if (cmd.inc)
            begin
                step_reg <= step_next;
            end
            freq_reg <= freq_next;
            if (cmd.setup)
            begin
                glide_reg <= target_reg != freq_reg;
                up_reg    <= target_reg > freq_reg;
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            target_reg <= req_target_freq;
            count_reg  <= sat_count[CNT_W-1:0];
            remain_reg <= sat_count[CNT_W-1:0];
        end
        else if (cmd.load)
        begin
            remain_reg <= remain_reg - CNT_W'(1);
        end
        if (cmd.setup || cmd.div_step)
        begin
            div_reg <= div_next;
            rem_reg <= rem_next;
        end
        if (cmd.setup)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.mul)
        begin
            prod_lo_reg <= {32'd0, freq_reg} * {31'd0, scale_reg[31:0]};
            prod_hi_reg <= hi_full[31:0];
        end
        if (cmd.load)
        begin
            sample_reg <= rom_data;
            last_reg   <= remain_reg == CNT_W'(1);
        end
    end

    assign rom_addr = phase_reg[PHASE_W-1 -: ADDR_W];

    assign status.glide      = target_reg != freq_reg;
    assign status.glide_mode = glide_reg;
    assign status.div_last   = div_cnt_reg == DIV_LAST_STEP;
    assign status.rem_one    = remain_reg == CNT_W'(1);
    assign status.rem_zero   = remain_reg == '0;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.req_zero   = req_num_samples == '0;

    assign out_valid  = out_valid_reg;
    assign out_sample = sample_reg;
    assign out_last   = last_reg;
endmodule

// ----- hw/rtl/sine_oscillator_frequency_glide_core.sv -----
// Top level of the block-based sine oscillator with linear frequency glide.
// The block_req channel takes one request per audio block: a target frequency
// in unsigned Q.16 Hz and a sample count, where a count of zero is dropped and a
// count above MAX_BLOCK is cut to MAX_BLOCK. The samples channel then delivers
// that many sine samples, with last set on the final one.
// A request whose target equals the current frequency passes setup, a table read
// and a load for its first sample, then repeats the read and load per sample.
// A gliding request first runs a bit-serial divide for the frequency step and
// then, per sample, reads the table, loads the output, multiplies for the new
// increment, adds its rounding and updates the phase.
// One request is processed at a time; block_req.ready rises again once the final
// sample sits in the output register, or after a glide once the increment and phase
// are updated, so the next request is taken while that sample waits.
// A stalled receiver holds the output register and halts the block after the
// current sample. A phase scale write while idle recomputes the phase increment in
// multiply and increment states. Reset restores 500 Hz at 48 kHz with zero phase.
module sine_oscillator_frequency_glide_core #(
    parameter int MAX_BLOCK        = 64,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    sog_req_if.sink                     block_req,
    sog_smp_if.source                   samples,
    input  logic                        cfg_we,
    input  logic [sog_pkg::SCALE_W-1:0] cfg_wdata
);
    import sog_pkg::*;

    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1) - 1;

    sog_cmd_t         cmd;
    sog_status_t      status;
    logic [ADDR_W-1:0] rom_addr;
    logic [SMP_W-1:0]  rom_data;

    sog_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (block_req.valid),
        .req_ready (block_req.ready),
        .cfg_we    (cfg_we),
        .status    (status),
        .cmd       (cmd)
    );

    sog_datapath #(
        .MAX_BLOCK (MAX_BLOCK),
        .ADDR_W    (ADDR_W)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .req_target_freq (block_req.target_freq),
        .req_num_samples (block_req.num_samples),
        .out_ready       (samples.ready),
        .out_valid       (samples.valid),
        .out_sample      (samples.sample_value),
        .out_last        (samples.last),
        .rom_addr        (rom_addr),
        .rom_data        (rom_data)
    );

    sog_sine_rom #(
        .ADDR_W (ADDR_W)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );
endmodule

// ----- hw/rtl/sog_checker.sv -----
// Port-level assertions for the oscillator top level and the bind that attaches them.
module sog_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic [sog_pkg::NS_W-1:0]    num_samples,
    input logic                        smp_valid,
    input logic                        smp_ready,
    input logic [sog_pkg::SMP_W-1:0]   sample_value,
    input logic                        smp_last,
    input logic                        cfg_we
);
    import sog_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && !smp_ready |=> smp_valid && $stable(sample_value) && $stable(smp_last))
        else $error("Stalled sample changed before it was taken.");

    a_amp_cap: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid |-> sample_value != {1'b1, {(SMP_W-1){1'b0}}})
        else $error("Sample exceeds the amplitude cap.");

    a_busy_mid_block: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && !smp_last |-> !req_ready)
        else $error("Request taken while a block is still in progress.");

    a_zero_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && num_samples == '0 |=> req_ready || cfg_we)
        else $error("Empty request did not leave the block idle.");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && num_samples != '0 |=> !req_ready)
        else $error("Block took a request while starting another.");
endmodule

bind sine_oscillator_frequency_glide_core sog_checker u_sog_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (block_req.valid),
    .req_ready    (block_req.ready),
    .num_samples  (block_req.num_samples),
    .smp_valid    (samples.valid),
    .smp_ready    (samples.ready),
    .sample_value (samples.sample_value),
    .smp_last     (samples.last),
    .cfg_we       (cfg_we)
);

// ----- dv/testbench.sv -----
// Testbench for the glide sine oscillator: random request stream, own sample predictor, checks.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sog_pkg::*;

    localparam int MAX_BLOCK   = 64;
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH + 1) - 1;
    localparam int SETTLE      = 50;

    localparam logic [FREQ_W-1:0]  FREQ_TOP   = 31'd1572864000;
    localparam logic [FREQ_W-1:0]  FREQ_ALL   = {FREQ_W{1'b1}};
    localparam logic [SCALE_W-1:0] SCALE_LOW  = 36'd1466015503;
    localparam logic [SCALE_W-1:0] SCALE_HIGH = 36'd35184372088;
    localparam logic [SCALE_W-1:0] SCALE_ALL  = {SCALE_W{1'b1}};

    localparam longint unsigned QUARTER = 64'd1073741824;
    localparam longint unsigned TAYLOR [5] = '{
        64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026993, 64'd172272
    };

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [NS_W-1:0]   count;
    } block_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] value;
        logic                    last;
    } sample_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [SCALE_W-1:0] cfg_wdata;

    sog_req_if req_ch ();
    sog_smp_if smp_ch ();

    sine_oscillator_frequency_glide_core #(
        .MAX_BLOCK        (MAX_BLOCK),
        .SINE_TABLE_DEPTH (TABLE_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .block_req (req_ch),
        .samples   (smp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Oscillator state as the block should hold it.
    logic [SCALE_W-1:0] osc_scale;
    logic [PHASE_W-1:0] osc_phase;
    logic [PHASE_W-1:0] osc_step;
    logic [FREQ_W-1:0]  osc_freq;

    block_t  pending_blocks [$];
    sample_t expected_samples [$];
    logic [FREQ_W-1:0] gen_freq;

    logic    calm;
    int      req_gap;
    int      smp_stall;
    int      errors;
    int      blocks_taken;
    int      glide_blocks;
    int      samples_checked;
    int      scale_writes;

    always #5 clk = ~clk;

    function automatic logic [PHASE_W-1:0] freq_to_step(logic [FREQ_W-1:0] f,
                                                          logic [SCALE_W-1:0] scale);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned r;
        lo = 64'(scale[31:0]);
        hi = 64'(scale[35:32]);
        r = longint'(f) * hi + ((longint'(f) * lo + 64'h8000_0000) >> 32);
        return r[31:0];
    endfunction

    function automatic logic signed [SMP_W-1:0] sine_of_phase(logic [PHASE_W-1:0] ph);
        logic [31:0] top;
        longint unsigned u;
        longint unsigned sq;
        longint unsigned acc;
        longint unsigned prod;
        longint unsigned mag;
        longint unsigned v;
        top = ph & (32'hFFFF_FFFF << (32 - ADDR_BITS));
        u = 64'(top[29:0]);
        if (top[30])
        begin
            u = QUARTER - u;
        end
        sq = (u * u) >> 30;
        acc = TAYLOR[4];
        for (int i = 3; i >= 0; i--)
        begin
            prod = (acc * sq) >> 30;
            acc = (TAYLOR[i] > prod) ? TAYLOR[i] - prod : 64'd0;
        end
        mag = (acc * u) >> 30;
        v = (mag * 64'd4095 + (64'd1 << 29)) >> 30;
        if (v > 64'd4095)
        begin
            v = 64'd4095;
        end
        if (top[31])
        begin
            v = 64'd0 - v;
        end
        return v[SMP_W-1:0];
    endfunction

    task automatic render_block(block_t b);
        int n;
        logic up;
        logic [FREQ_W-1:0] diff;
        logic [FREQ_W-1:0] ramp;
        sample_t s;
        n = (b.count > MAX_BLOCK) ? MAX_BLOCK : int'(b.count);
        if (n == 0)
        begin
            return;
        end
        blocks_taken++;
        if (b.freq != osc_freq)
        begin
            glide_blocks++;
            up = b.freq > osc_freq;
            diff = up ? b.freq - osc_freq : osc_freq - b.freq;
            ramp = FREQ_W'(diff / n);
            for (int k = 0; k < n; k++)
            begin
                s.value = sine_of_phase(osc_phase);
                s.last = (k == n - 1);
                expected_samples.push_back(s);
                osc_freq = up ? osc_freq + ramp : osc_freq - ramp;
                osc_step = freq_to_step(osc_freq, osc_scale);
                osc_phase = osc_phase + osc_step;
            end
            osc_freq = b.freq;
        end
        else
        begin
            for (int k = 0; k < n; k++)
            begin
                s.value = sine_of_phase(osc_phase);
                s.last = (k == n - 1);
                expected_samples.push_back(s);
                osc_phase = osc_phase + osc_step;
            end
        end
    endtask

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_gap <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                render_block({req_ch.target_freq, req_ch.num_samples});
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_gap != 0)
                begin
                    req_gap <= req_gap - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_blocks.size() != 0)
                begin
                    if (!calm && $urandom_range(0, 7) == 0)
                    begin
                        req_gap <= $urandom_range(1, 15) - 1;
                        req_ch.valid <= 1'b0;
                    end
                    else
                    begin
                        req_ch.valid <= 1'b1;
                        req_ch.target_freq <= pending_blocks[0].freq;
                        req_ch.num_samples <= pending_blocks[0].count;
                        void'(pending_blocks.pop_front());
                    end
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Sample monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_ch.ready <= 1'b0;
            smp_stall <= 0;
        end
        else
        begin
            if (smp_ch.valid && smp_ch.ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: unexpected sample, expected none, got value %0d last %0b",
                             $time, $signed(smp_ch.sample_value), smp_ch.last);
                    errors++;
                end
                else
                begin
                    if (smp_ch.sample_value !== expected_samples[0].value ||
                        smp_ch.last !== expected_samples[0].last)
                    begin
                        $display("%0t: sample %0d expected value %0d last %0b, got value %0d last %0b",
                                 $time, samples_checked, $signed(expected_samples[0].value),
                                 expected_samples[0].last, $signed(smp_ch.sample_value),
                                 smp_ch.last);
                        errors++;
                    end
                    void'(expected_samples.pop_front());
                end
                samples_checked++;
            end
            if (smp_stall != 0)
            begin
                smp_stall <= smp_stall - 1;
                smp_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                smp_stall <= $urandom_range(1, 15) - 1;
                smp_ch.ready <= 1'b0;
            end
            else
            begin
                smp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic queue_block(logic [FREQ_W-1:0] f, logic [NS_W-1:0] n);
        block_t b;
        b.freq = f;
        b.count = n;
        pending_blocks.push_back(b);
        if (n != 0)
        begin
            gen_freq = f;
        end
    endtask

    task automatic queue_random_block();
        int pick;
        logic [FREQ_W-1:0] f;
        logic [NS_W-1:0] n;
        int delta;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            n = NS_W'($urandom_range(1, 16));
        end
        else if (pick < 90)
        begin
            n = NS_W'($urandom_range(17, MAX_BLOCK));
        end
        else if (pick < 96)
        begin
            n = NS_W'($urandom_range(MAX_BLOCK + 1, 127));
        end
        else
        begin
            n = '0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            f = gen_freq;
        end
        else if (pick < 70)
        begin
            f = FREQ_W'($urandom_range(0, FREQ_TOP));
        end
        else if (pick < 85)
        begin
            delta = $urandom_range(0, 200) - 100;
            f = gen_freq + FREQ_W'(delta);
        end
        else
        begin
            f = FREQ_W'($urandom);
        end
        queue_block(f, n);
    endtask

    function automatic logic quiet();
        return pending_blocks.size() == 0 && !req_ch.valid && expected_samples.size() == 0;
    endfunction

    task automatic wait_quiet();
        while (!quiet())
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_scale(logic [SCALE_W-1:0] v);
        wait_quiet();
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        osc_scale = v;
        osc_step = freq_to_step(osc_freq, osc_scale);
        scale_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [SCALE_W-1:0] scale_set [6];
        logic [63:0] r;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.target_freq = '0;
        req_ch.num_samples = '0;
        smp_ch.ready = 1'b0;
        calm = 1'b0;
        req_gap = 0;
        smp_stall = 0;
        errors = 0;
        blocks_taken = 0;
        glide_blocks = 0;
        samples_checked = 0;
        scale_writes = 0;
        osc_scale = SCALE_RESET;
        osc_phase = '0;
        osc_step = STEP_RESET;
        osc_freq = FREQ_RESET;
        gen_freq = FREQ_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at the reset scale.
        queue_block(FREQ_RESET, 7'd1);
        queue_block(FREQ_RESET, 7'd64);
        queue_block(31'd0, 7'd64);
        queue_block(31'd0, 7'd0);
        queue_block(FREQ_ALL, 7'd1);
        queue_block(FREQ_TOP, 7'd127);
        queue_block(FREQ_TOP, 7'd65);
        queue_block(FREQ_TOP + 31'd5, 7'd64);
        queue_block(FREQ_TOP, 7'd3);
        queue_block(31'd12345, 7'd0);
        queue_block(FREQ_RESET, 7'd7);
        queue_block(FREQ_RESET - 31'd1000, 7'd33);
        queue_block(31'd1, 7'd1);
        queue_block(31'd0, 7'd2);
        queue_block(31'h4000_0000, 7'd16);
        queue_block(FREQ_ALL, 7'd64);
        queue_block(31'd0, 7'd127);
        queue_block(31'd12345678, 7'd100);
        wait_quiet();

        r = {$urandom, $urandom};
        scale_set[0] = SCALE_LOW;
        scale_set[1] = SCALE_HIGH;
        scale_set[2] = '0;
        scale_set[3] = SCALE_ALL;
        scale_set[4] = SCALE_LOW + SCALE_W'(r % (SCALE_HIGH - SCALE_LOW + 1));
        scale_set[5] = SCALE_RESET;

        for (int p = 0; p < 6; p++)
        begin
            write_scale(scale_set[p]);
            if (p == 5)
            begin
                calm = 1'b1;
            end
            repeat (44) queue_random_block();
            wait_quiet();
        end

        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d blocks (%0d gliding) and %0d samples over %0d phase scale writes.",
                 blocks_taken, glide_blocks, samples_checked, scale_writes);
        $display("Requests and samples both saw random idle bursts, with a final stretch at full rate.");
        if (errors == 0 && expected_samples.size() == 0)
        begin
            $display("PASS sine_oscillator_frequency_glide_core");
        end
        else
        begin
            $display("FAIL sine_oscillator_frequency_glide_core");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timed out with %0d samples still expected.", expected_samples.size());
        $display("FAIL sine_oscillator_frequency_glide_core");
        $finish;
    end

endmodule
